[hdl/bgi_pkg.sv]
// Shared codes, defaults and state types for the bilinear grid interpolator.
package bgi_pkg;

  // Default sizes handed down from the top level
  localparam int MAX_X_DEF       = 64;
  localparam int MAX_Y_DEF       = 64;
  localparam int VALUE_WIDTH_DEF = 32;

  // Port widths fixed by the item format
  localparam int IN_TDATA_W  = 112;
  localparam int OUT_TDATA_W = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 7;

  // Item kinds carried on in_tuser
  localparam logic [1:0] FN_WR_X    = 2'd0;
  localparam logic [1:0] FN_WR_Y    = 2'd1;
  localparam logic [1:0] FN_WR_GRID = 2'd2;
  localparam logic [1:0] FN_EVAL    = 2'd3;

  // Result status carried on out_tuser
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_X_POINTS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_POINTS = 2'd1;

  // Segment search sequencer
  typedef enum logic [2:0] {
    SR_IDLE,
    SR_FIRST,
    SR_LAST,
    SR_SCAN,
    SR_LO,
    SR_HI,
    SR_DONE
  } srch_state_t;

  // Top level sequencer
  typedef enum logic [2:0] {
    T_IDLE,
    T_SEARCH,
    T_DIVX,
    T_DIVY,
    T_GRID,
    T_BLEND,
    T_OUT
  } top_state_t;

endpackage

[hdl/bilinear_grid_interpolator_core.sv]
// Top level: table loading, evaluation sequencer, corner blend and output register.
//
// Usage: items arrive on in_* with the item kind on in_tuser (write x
// breakpoint, write y breakpoint, write grid value, evaluate). Writes give no
// result. An evaluate beat gives one result beat on out_*: the value on
// out_tdata and the status (ok, saturated, zero-width segment) on out_tuser.
// An evaluate runs the two segment searches in parallel, then, unless a
// segment has zero width, two offset divisions on one shared divider, four
// grid RAM reads and three blends; the result then goes to the output register.
// One item is in work at a time; in_tready is high only while idle.
// The result sits in an output register; a stalled receiver holds it there
// and a following item is still taken, but its result waits until the
// register is free. Reset sets both point counts to 2 and empties the output
// register; table contents are undefined until written.
// The user must write configuration through cfg_we/cfg_index/cfg_wdata
// only while idle; the block itself does not enforce this.
module bilinear_grid_interpolator_core import bgi_pkg::*; #(
  parameter int MAX_X_POINTS = MAX_X_DEF,
  parameter int MAX_Y_POINTS = MAX_Y_DEF,
  parameter int VALUE_WIDTH  = VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // x_index[5:0], y_index[11:6], write_value[43:12], query_x[75:44],
  // query_y[107:76], zero fill[111:108]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // func[1:0]
  input  logic [1:0]             in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // interpolated[31:0]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // status[1:0]
  output logic [1:0]             out_tuser,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int VW  = VALUE_WIDTH;
  localparam int XAW = $clog2(MAX_X_POINTS);
  localparam int YAW = $clog2(MAX_Y_POINTS);
  localparam int XNW = $clog2(MAX_X_POINTS + 1);
  localparam int YNW = $clog2(MAX_Y_POINTS + 1);
  localparam int GD  = MAX_X_POINTS * MAX_Y_POINTS;
  localparam int GAW = $clog2(GD);
  localparam int TW  = 64 - VW;
  localparam int PW  = TW + VW + 1;
  localparam int SW  = PW + 1;
  localparam logic signed [63:0] VMAX = (64'sd1 <<< (VW - 1)) - 64'sd1;
  localparam logic signed [63:0] VMIN = -VMAX - 64'sd1;

  // Clamp a 32-bit item value into the value format
  function automatic logic signed [VW-1:0] sat_in(input logic signed [31:0] x);
    logic signed [63:0] w;
    w = 64'(x);
    if (w > VMAX) return VW'(VMAX);
    if (w < VMIN) return VW'(VMIN);
    return VW'(w);
  endfunction

  // Input fields
  logic [5:0]         f_xi, f_yi;
  logic signed [31:0] f_wval, f_qx, f_qy;
  logic               in_acc, eval_acc;

  assign f_xi     = in_tdata[5:0];
  assign f_yi     = in_tdata[11:6];
  assign f_wval   = $signed(in_tdata[43:12]);
  assign f_qx     = $signed(in_tdata[75:44]);
  assign f_qy     = $signed(in_tdata[107:76]);
  assign in_acc   = in_tvalid && in_tready;
  assign eval_acc = in_acc && (in_tuser == FN_EVAL);

  top_state_t state_r, state_nxt;

  logic [CFG_DATA_W-1:0] xn_r, yn_r;
  logic [XNW-1:0]        nx;
  logic [YNW-1:0]        ny;
  logic signed [VW-1:0]  wval_s, qx_r, qy_r;

  // Search units
  logic                 x_done, y_done, xdone_r, ydone_r, both_done;
  logic [XAW-1:0]       x_seg;
  logic [YAW-1:0]       y_seg;
  logic signed [VW-1:0] x_lo, x_hi, y_lo, y_hi;
  logic                 zero_w;

  // Divider
  logic                 div_start, div_done, div_sat;
  logic signed [VW:0]   div_num, div_den;
  logic signed [TW-1:0] div_t, tx_r, ty_r;

  // Grid and blend
  logic [GAW-1:0]       gbase_r, g_waddr, g_raddr, g_off;
  logic [VW-1:0]        g_raw;
  logic [2:0]           gcnt_r, bcnt_r;
  logic signed [VW-1:0] z_r [4];
  logic signed [VW-1:0] a_r, b_r, r_r;
  logic signed [VW-1:0] bl_lo, bl_hi;
  logic signed [TW-1:0] bl_t;
  logic signed [VW:0]   bl_diff;
  logic signed [PW-1:0] prod_r, prod_nxt, prod_sh;
  logic signed [SW-1:0] sum;
  logic signed [VW-1:0] bl_res;
  logic                 bl_sat;
  logic                 sat_r, zero_r;

  // Output register
  logic                   out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic [1:0]             out_tuser_r;
  logic                   out_load;

  assign wval_s = sat_in(f_wval);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xn_r <= CFG_DATA_W'(2);
      yn_r <= CFG_DATA_W'(2);
    end else if (cfg_we) begin
      if (cfg_index == CFG_X_POINTS) xn_r <= cfg_wdata;
      else if (cfg_index == CFG_Y_POINTS) yn_r <= cfg_wdata;
    end
  end

  // Points in use, clamped to [2, table size]
  always_comb begin
    if (xn_r < CFG_DATA_W'(2)) nx = XNW'(2);
    else if (32'(xn_r) > MAX_X_POINTS) nx = XNW'(MAX_X_POINTS);
    else nx = XNW'(xn_r);
    if (yn_r < CFG_DATA_W'(2)) ny = YNW'(2);
    else if (32'(yn_r) > MAX_Y_POINTS) ny = YNW'(MAX_Y_POINTS);
    else ny = YNW'(yn_r);
  end

  // Searches compare against the query held since the evaluate beat
  bgi_search #(.MAXP(MAX_X_POINTS), .VW(VW)) u_xsrch (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_acc && (in_tuser == FN_WR_X) && (32'(f_xi) < MAX_X_POINTS)),
    .wr_addr (XAW'(f_xi)),
    .wr_data (wval_s),
    .start   (eval_acc),
    .n       (nx),
    .v       (qx_r),
    .done    (x_done),
    .seg     (x_seg),
    .b_lo    (x_lo),
    .b_hi    (x_hi)
  );

  bgi_search #(.MAXP(MAX_Y_POINTS), .VW(VW)) u_ysrch (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_acc && (in_tuser == FN_WR_Y) && (32'(f_yi) < MAX_Y_POINTS)),
    .wr_addr (YAW'(f_yi)),
    .wr_data (wval_s),
    .start   (eval_acc),
    .n       (ny),
    .v       (qy_r),
    .done    (y_done),
    .seg     (y_seg),
    .b_lo    (y_lo),
    .b_hi    (y_hi)
  );

  assign both_done = (xdone_r || x_done) && (ydone_r || y_done);
  assign zero_w    = (x_hi == x_lo) || (y_hi == y_lo);

  // Offset divisions, x first then y
  assign div_num = (state_r == T_SEARCH) ? (VW + 1)'(qx_r) - (VW + 1)'(x_lo)
                                         : (VW + 1)'(qy_r) - (VW + 1)'(y_lo);
  assign div_den = (state_r == T_SEARCH) ? (VW + 1)'(x_hi) - (VW + 1)'(x_lo)
                                         : (VW + 1)'(y_hi) - (VW + 1)'(y_lo);

  bgi_div #(.VW(VW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .t     (div_t),
    .sat   (div_sat)
  );

  // Grid value RAM, row stride MAX_Y_POINTS
  assign g_waddr = GAW'(32'(f_xi) * MAX_Y_POINTS + 32'(f_yi));

  always_comb begin
    case (gcnt_r[1:0])
      2'd0:    g_off = '0;
      2'd1:    g_off = GAW'(MAX_Y_POINTS);
      2'd2:    g_off = GAW'(1);
      default: g_off = GAW'(MAX_Y_POINTS + 1);
    endcase
  end
  assign g_raddr = gbase_r + g_off;

  bgi_ram #(.WIDTH(VW), .DEPTH(GD)) u_grid (
    .clk   (clk),
    .we    (in_acc && (in_tuser == FN_WR_GRID) && (32'(f_xi) < MAX_X_POINTS)
            && (32'(f_yi) < MAX_Y_POINTS)),
    .waddr (g_waddr),
    .wdata (wval_s),
    .raddr (g_raddr),
    .rdata (g_raw)
  );

  // Blend operands: z00..z10 then z01..z11 with tx, then a..b with ty
  always_comb begin
    case (bcnt_r[2:1])
      2'd0: begin
        bl_lo = z_r[0];
        bl_hi = z_r[1];
        bl_t  = tx_r;
      end
      2'd1: begin
        bl_lo = z_r[2];
        bl_hi = z_r[3];
        bl_t  = tx_r;
      end
      default: begin
        bl_lo = a_r;
        bl_hi = b_r;
        bl_t  = ty_r;
      end
    endcase
  end

  assign bl_diff  = (VW + 1)'(bl_hi) - (VW + 1)'(bl_lo);
  assign prod_nxt = bl_t * bl_diff;
  assign prod_sh  = prod_r >>> 16;
  assign sum      = SW'(bl_lo) + SW'(prod_sh);

  always_comb begin
    bl_sat = 1'b0;
    if (sum > SW'(VMAX)) begin
      bl_res = VW'(VMAX);
      bl_sat = 1'b1;
    end else if (sum < SW'(VMIN)) begin
      bl_res = VW'(VMIN);
      bl_sat = 1'b1;
    end else begin
      bl_res = VW'(sum);
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      T_IDLE:   if (eval_acc) state_nxt = T_SEARCH;
      T_SEARCH: if (both_done) state_nxt = zero_w ? T_OUT : T_DIVX;
      T_DIVX:   if (div_done) state_nxt = T_DIVY;
      T_DIVY:   if (div_done) state_nxt = T_GRID;
      T_GRID:   if (gcnt_r == 3'd4) state_nxt = T_BLEND;
      T_BLEND:  if (bcnt_r == 3'd5) state_nxt = T_OUT;
      T_OUT:    if (out_load) state_nxt = T_IDLE;
      default:  state_nxt = T_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_tready = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      T_IDLE:   in_tready = 1'b1;
      T_SEARCH: div_start = both_done && !zero_w;
      T_DIVX:   div_start = div_done;
      T_OUT:    out_load = !out_tvalid_r || out_tready;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_IDLE;
      xdone_r <= 1'b0;
      ydone_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (eval_acc) begin
        xdone_r <= 1'b0;
        ydone_r <= 1'b0;
      end else begin
        xdone_r <= xdone_r || x_done;
        ydone_r <= ydone_r || y_done;
      end
    end
  end

  // Evaluation datapath
  always_ff @(posedge clk) begin
    if (eval_acc) begin
      qx_r   <= sat_in(f_qx);
      qy_r   <= sat_in(f_qy);
      sat_r  <= 1'b0;
      zero_r <= 1'b0;
    end
    case (state_r)
      T_SEARCH: begin
        if (both_done) begin
          zero_r  <= zero_w;
          gbase_r <= GAW'(32'(x_seg) * MAX_Y_POINTS + 32'(y_seg));
        end
      end
      T_DIVX: begin
        if (div_done) begin
          tx_r  <= div_t;
          sat_r <= sat_r || div_sat;
        end
      end
      T_DIVY: begin
        gcnt_r <= '0;
        if (div_done) begin
          ty_r  <= div_t;
          sat_r <= sat_r || div_sat;
        end
      end
      T_GRID: begin
        if (gcnt_r != 3'd0) z_r[gcnt_r[1:0] - 2'd1] <= $signed(g_raw);
        gcnt_r <= gcnt_r + 3'd1;
        bcnt_r <= '0;
      end
      T_BLEND: begin
        bcnt_r <= bcnt_r + 3'd1;
        if (!bcnt_r[0]) begin
          prod_r <= prod_nxt;
        end else begin
          sat_r <= sat_r || bl_sat;
          case (bcnt_r[2:1])
            2'd0:    a_r <= bl_res;
            2'd1:    b_r <= bl_res;
            default: r_r <= bl_res;
          endcase
        end
      end
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= zero_r ? '0 : OUT_TDATA_W'(r_r);
      out_tuser_r <= zero_r ? ST_ZERO : (sat_r ? ST_SAT : ST_OK);
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // An evaluate beat closes the input until its result is done
  a_eval_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    eval_acc |=> !in_tready)
    else $error("input taken right after an evaluate beat");

  // Zero-width result carries a zero value
  a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_ZERO) |-> out_tdata == '0)
    else $error("zero-width status with nonzero value");

  // Division starts only after both searches finished
  a_div_after_search: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == T_DIVX) |-> xdone_r && ydone_r)
    else $error("division running before both searches finished");

endmodule

[hdl/bgi_ram.sv]
// Generic simple dual-port RAM with registered read.
module bgi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/bgi_search.sv]
// Breakpoint table with a linear segment search over its RAM.
module bgi_search import bgi_pkg::*; #(
  parameter int MAXP = MAX_X_DEF,
  parameter int VW   = VALUE_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        wr_en,
  input  logic [$clog2(MAXP)-1:0]     wr_addr,
  input  logic signed [VW-1:0]        wr_data,
  input  logic                        start,
  input  logic [$clog2(MAXP+1)-1:0]   n,
  input  logic signed [VW-1:0]        v,
  output logic                        done,
  output logic [$clog2(MAXP)-1:0]     seg,
  output logic signed [VW-1:0]        b_lo,
  output logic signed [VW-1:0]        b_hi
);

  localparam int AW = $clog2(MAXP);
  localparam int NW = $clog2(MAXP + 1);

  srch_state_t state_r, state_nxt;
  logic [NW-1:0]        k_r;
  logic [AW-1:0]        seg_r;
  logic signed [VW-1:0] first_r, prev_r, lo_r, hi_r;
  logic [AW-1:0]        rd_addr;
  logic [VW-1:0]        rd_raw;
  logic signed [VW-1:0] rd_data;
  logic [NW-1:0]        nm1, nm2, k_inc;
  logic                 below, above, hit, at_end;

  bgi_ram #(.WIDTH(VW), .DEPTH(MAXP)) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_raw)
  );

  assign rd_data = $signed(rd_raw);
  assign nm1     = n - NW'(1);
  assign nm2     = n - NW'(2);
  assign k_inc   = k_r + NW'(1);
  assign below   = v < first_r;
  assign above   = v > rd_data;
  assign hit     = (v >= prev_r) && (v <= rd_data);
  assign at_end  = (k_r == nm1);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      SR_IDLE:  if (start) state_nxt = SR_FIRST;
      SR_FIRST: state_nxt = SR_LAST;
      SR_LAST:  state_nxt = (below || above) ? SR_LO : SR_SCAN;
      SR_SCAN: begin
        if (hit) state_nxt = SR_DONE;
        else if (at_end) state_nxt = SR_LO;
      end
      SR_LO:    state_nxt = SR_HI;
      SR_HI:    state_nxt = SR_DONE;
      SR_DONE:  state_nxt = SR_IDLE;
      default:  state_nxt = SR_IDLE;
    endcase
  end

  // Read address and outputs
  always_comb begin
    rd_addr = '0;
    done    = 1'b0;
    case (state_r)
      SR_IDLE:  rd_addr = '0;
      SR_FIRST: rd_addr = nm1[AW-1:0];
      SR_LAST: begin
        if (below) rd_addr = '0;
        else if (above) rd_addr = nm2[AW-1:0];
        else rd_addr = AW'(1);
      end
      SR_SCAN:  rd_addr = at_end ? '0 : k_inc[AW-1:0];
      SR_LO:    rd_addr = seg_r + AW'(1);
      SR_HI:    rd_addr = '0;
      SR_DONE:  done = 1'b1;
      default:  rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SR_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      SR_FIRST: first_r <= rd_data;
      SR_LAST: begin
        prev_r <= first_r;
        k_r    <= NW'(1);
        if (below) seg_r <= '0;
        else if (above) seg_r <= nm2[AW-1:0];
      end
      SR_SCAN: begin
        if (hit) begin
          seg_r <= AW'(k_r - NW'(1));
          lo_r  <= prev_r;
          hi_r  <= rd_data;
        end else if (at_end) begin
          // unordered table: fall back to the first segment
          seg_r <= '0;
        end else begin
          prev_r <= rd_data;
          k_r    <= k_inc;
        end
      end
      SR_LO:   lo_r <= rd_data;
      SR_HI:   hi_r <= rd_data;
      default: ;
    endcase
  end

  assign seg  = seg_r;
  assign b_lo = lo_r;
  assign b_hi = hi_r;

endmodule

[hdl/bgi_div.sv]
// Restoring divider for the Q16.16 segment offset, one quotient bit per cycle.
module bgi_div import bgi_pkg::*; #(
  parameter int VW = VALUE_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [VW:0]   num,
  input  logic signed [VW:0]   den,
  output logic                 done,
  output logic signed [63-VW:0] t,
  output logic                 sat
);

  localparam int DW = VW + 17;
  localparam int CW = $clog2(DW + 1);
  localparam int TW = 64 - VW;
  localparam logic [63:0] TLIM = 64'd1 << (63 - VW);

  logic          busy_r, fin_r, neg_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] dvd_r;
  logic [VW:0]   rem_r, dsr_r;
  logic [VW:0]   un, ud;
  logic [VW+1:0] trial;
  logic          ge;
  logic [63:0]   q64, qs;

  assign un    = num[VW] ? (VW + 1)'(0) - num : num;
  assign ud    = den[VW] ? (VW + 1)'(0) - den : den;
  assign trial = {rem_r, dvd_r[DW-1]};
  assign ge    = trial >= {1'b0, dsr_r};

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      cnt_r  <= '0;
    end else begin
      fin_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end
    end
  end

  // Shift and subtract
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= {un, 16'd0};
      dsr_r <= ud;
      rem_r <= '0;
      neg_r <= num[VW] != den[VW];
    end else if (busy_r) begin
      rem_r <= ge ? (VW + 1)'(trial - {1'b0, dsr_r}) : trial[VW:0];
      dvd_r <= {dvd_r[DW-2:0], ge};
    end
  end

  // Signed, saturated offset
  assign q64 = 64'(dvd_r);
  always_comb begin
    if (neg_r) begin
      sat = q64 > TLIM;
      qs  = sat ? TLIM : q64;
      t   = TW'(64'd0 - qs);
    end else begin
      sat = q64 > (TLIM - 64'd1);
      qs  = sat ? (TLIM - 64'd1) : q64;
      t   = TW'(qs);
    end
  end

  assign done = fin_r;

endmodule

[tb/sv/bgi_result_checker.sv]
// Result checker for the bilinear grid interpolator: mirrors tables and registers, predicts results.
`timescale 1ns / 100ps
module bgi_result_checker import bgi_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [1:0]             in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic [1:0]             out_tuser,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  output int                     errors,
  output int                     pending,
  output int                     evals_seen,
  output int                     sat_seen,
  output int                     zero_seen
);

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  status;
  } interp_result_t;

  localparam longint VMAX = 64'sd2147483647;
  localparam longint VMIN = -64'sd2147483648;
  localparam longint unsigned TLIM = 64'd1 << 31;

  interp_result_t    interp_q[$];
  logic signed [31:0] x_bp [64];
  logic signed [31:0] y_bp [64];
  logic signed [31:0] grid [64][64];
  logic [6:0]         x_pts, y_pts;

  initial begin
    errors = 0; pending = 0; evals_seen = 0; sat_seen = 0; zero_seen = 0;
  end

  function automatic int unsigned eff_points(logic [6:0] r);
    if (r < 2) return 2;
    if (r > 64) return 64;
    return r;
  endfunction

  function automatic longint clamp32(longint v, inout bit sat);
    if (v > VMAX) begin sat = 1; return VMAX; end
    if (v < VMIN) begin sat = 1; return VMIN; end
    return v;
  endfunction

  // First segment containing v; clamps to the end segments outside the table
  function automatic int unsigned find_seg(bit on_x, int unsigned n, longint v);
    longint lo, hi, b0, bn;
    b0 = on_x ? x_bp[0] : y_bp[0];
    bn = on_x ? x_bp[n-1] : y_bp[n-1];
    if (v >= b0 && v <= bn) begin
      for (int unsigned k = 0; k + 1 < n; k++) begin
        lo = on_x ? x_bp[k] : y_bp[k];
        hi = on_x ? x_bp[k+1] : y_bp[k+1];
        if (v >= lo && v <= hi) return k;
      end
      return 0;
    end
    return (v < b0) ? 0 : n - 2;
  endfunction

  // Q16 offset, truncated toward zero, saturated to 32 signed bits
  function automatic longint q16_offset(longint num, longint den, inout bit sat);
    bit neg;
    longint unsigned un, ud, q;
    neg = (num < 0) != (den < 0);
    un = (num < 0) ? -num : num;
    ud = (den < 0) ? -den : den;
    q = (un << 16) / ud;
    if (neg) begin
      if (q > TLIM) begin sat = 1; q = TLIM; end
      return -longint'(q);
    end
    if (q > TLIM - 1) begin sat = 1; q = TLIM - 1; end
    return longint'(q);
  endfunction

  function automatic longint lerp(longint lo, longint hi, longint t, inout bit sat);
    return clamp32(lo + ((t * (hi - lo)) >>> 16), sat);
  endfunction

  function automatic interp_result_t interpolate(longint qx, longint qy);
    interp_result_t r;
    bit sat;
    int unsigned i, j;
    longint wx, wy, tx, ty, a, b, v;
    sat = 0;
    i = find_seg(1, eff_points(x_pts), qx);
    j = find_seg(0, eff_points(y_pts), qy);
    wx = longint'(x_bp[i+1]) - x_bp[i];
    wy = longint'(y_bp[j+1]) - y_bp[j];
    if (wx == 0 || wy == 0) begin
      r.value = '0;
      r.status = ST_ZERO;
      return r;
    end
    tx = q16_offset(qx - x_bp[i], wx, sat);
    ty = q16_offset(qy - y_bp[j], wy, sat);
    a = lerp(grid[i][j], grid[i+1][j], tx, sat);
    b = lerp(grid[i][j+1], grid[i+1][j+1], tx, sat);
    v = lerp(a, b, ty, sat);
    r.value = v[31:0];
    r.status = sat ? ST_SAT : ST_OK;
    return r;
  endfunction

  always @(posedge clk) begin
    interp_result_t exp_r;
    logic [5:0] xi, yi;
    logic signed [31:0] wv, qx, qy;
    if (!rst_n) begin
      x_pts = 2;
      y_pts = 2;
      interp_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_X_POINTS) x_pts = cfg_wdata;
        else if (cfg_index == CFG_Y_POINTS) y_pts = cfg_wdata;
      end
      // input beat: update tables or queue a prediction
      if (in_tvalid && in_tready) begin
        {qy, qx, wv, yi, xi} = in_tdata[107:0];
        case (in_tuser)
          FN_WR_X:    x_bp[xi] = wv;
          FN_WR_Y:    y_bp[yi] = wv;
          FN_WR_GRID: grid[xi][yi] = wv;
          FN_EVAL:    interp_q.push_back(interpolate(qx, qy));
          default: ;
        endcase
      end
      // result beat: compare with the oldest prediction
      if (out_tvalid && out_tready) begin
        if (interp_q.size() == 0) begin
          $error("result beat with nothing expected: interpolated %h status %0d",
                 out_tdata, out_tuser);
          errors++;
        end else begin
          exp_r = interp_q.pop_front();
          evals_seen++;
          if (exp_r.status == ST_SAT) sat_seen++;
          if (exp_r.status == ST_ZERO) zero_seen++;
          if (out_tdata !== exp_r.value) begin
            $error("interpolated: expected %h actual %h", exp_r.value, out_tdata);
            errors++;
          end
          if (out_tuser !== exp_r.status) begin
            $error("status: expected %0d actual %0d", exp_r.status, out_tuser);
            errors++;
          end
        end
      end
    end
    pending = interp_q.size();
  end

endmodule

[tb/sv/bilinear_grid_interpolator_core_test.sv]
// Top of the interpolator testbench: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 100ps
module bilinear_grid_interpolator_core_test;
  import bgi_pkg::*;

  localparam int STALL_LIMIT = 20000;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [1:0]             in_tuser = FN_WR_X;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [1:0]             out_tuser;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = CFG_X_POINTS;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  int errors, pending, evals_seen, sat_seen, zero_seen;
  int tx_idle_pct = 14, rx_idle_pct = 59;
  int quiet_cycles = 0;
  bit hold_req = 0;
  int nx = 2, ny = 2;
  logic signed [31:0] x_copy [64];
  logic signed [31:0] y_copy [64];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  bilinear_grid_interpolator_core dut (.*);

  bgi_result_checker chk (.*);

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (600) @(negedge clk);
        hold_req = 0;
      end
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("bilinear_grid_interpolator_core verification failed");
      $finish;
    end
  end

  // one input beat; entered and left at a falling edge with valid high
  task automatic feed_item(logic [1:0] fn, logic [5:0] xi, logic [5:0] yi,
                           logic [31:0] wv, logic [31:0] qx, logic [31:0] qy);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= fn;
    in_tdata  <= {4'b0, qy, qx, wv, yi, xi};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_bp(bit on_x, int k, logic [31:0] v);
    if (on_x) begin
      x_copy[k] = v;
      feed_item(FN_WR_X, k, $urandom, v, $urandom, $urandom);
    end else begin
      y_copy[k] = v;
      feed_item(FN_WR_Y, $urandom, k, v, $urandom, $urandom);
    end
  endtask

  task automatic evaluate_at(logic [31:0] qx, logic [31:0] qy);
    feed_item(FN_EVAL, $urandom, $urandom, $urandom, qx, qy);
  endtask

  // stop offering, wait for every expected result, then let the block settle
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_points(logic [6:0] xr, logic [6:0] yr);
    cfg_we <= 1'b1; cfg_index <= CFG_X_POINTS; cfg_wdata <= xr;
    @(negedge clk);
    cfg_index <= CFG_Y_POINTS; cfg_wdata <= yr;
    @(negedge clk);
    cfg_we <= 1'b0;
    nx = (xr < 2) ? 2 : (xr > 64) ? 64 : xr;
    ny = (yr < 2) ? 2 : (yr > 64) ? 64 : yr;
  endtask

  // breakpoint table in one of several shapes
  task automatic load_axis(bit on_x, int n, int shape);
    longint v, stepv;
    v = -longint'($urandom_range(1 << 22));
    for (int k = 0; k < n; k++) begin
      case (shape)
        0: stepv = $urandom_range(1, 1 << 18);
        1: stepv = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 1 << 17);
        2: stepv = $urandom_range(1, 3);
        3: stepv = 0;
        default: stepv = 0;
      endcase
      if (shape == 3) v = -64'sd2147483648 + (longint'(k) * 64'sd4294967295) / (n - 1);
      else if (shape == 4) v = $signed($urandom_range(1 << 20)) - (1 << 19);
      else if (k > 0) v = v + stepv;
      write_bp(on_x, k, v[31:0]);
    end
  endtask

  function automatic logic [31:0] pick_coord(bit on_x, int n);
    int k;
    longint lo, hi;
    case ($urandom_range(9))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      2: return on_x ? x_copy[$urandom_range(n-1)] : y_copy[$urandom_range(n-1)];
      default: begin
        k = $urandom_range(n - 2);
        lo = on_x ? x_copy[k] : y_copy[k];
        hi = on_x ? x_copy[k+1] : y_copy[k+1];
        lo = lo + ((hi - lo) * longint'($urandom_range(65536))) / 65536;
        return lo[31:0];
      end
    endcase
  endfunction

  initial begin
    logic [6:0] xr, yr;
    bit wide_vals;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: unit cell with extreme corners, then a zero-width segment
    write_bp(1, 0, 32'h0);
    write_bp(1, 1, 32'h10000);
    write_bp(0, 0, 32'h0);
    write_bp(0, 1, 32'h10000);
    feed_item(FN_WR_GRID, 0, 0, 32'h7fffffff, 0, 0);
    feed_item(FN_WR_GRID, 1, 0, 32'h80000000, 0, 0);
    feed_item(FN_WR_GRID, 0, 1, 32'h0, 0, 0);
    feed_item(FN_WR_GRID, 1, 1, 32'd12345, 0, 0);
    evaluate_at(32'h0, 32'h0);
    evaluate_at(32'h10000, 32'h10000);
    evaluate_at(32'h8000, 32'h8000);
    evaluate_at(32'h7fffffff, 32'h80000000);
    evaluate_at(32'h80000000, 32'h7fffffff);
    evaluate_at(32'hffff0000, 32'h18000);
    write_bp(1, 1, 32'h0);
    evaluate_at(32'h4000, 32'h4000);
    drain();

    // phases of table size, shape and idling pattern
    for (int p = 0; p < 12; p++) begin
      if (p == 4) begin tx_idle_pct = 59; rx_idle_pct = 14; end
      if (p == 8) begin tx_idle_pct = 0; rx_idle_pct = 0; end
      case (p)
        2: begin xr = 127; yr = 2; end
        6: begin xr = 2; yr = 64; end
        9: begin xr = 64; yr = 0; end
        default: begin xr = $urandom_range(6); yr = $urandom_range(1, 6); end
      endcase
      set_points(xr, yr);
      @(negedge clk);
      load_axis(1, nx, $urandom_range(4));
      load_axis(0, ny, $urandom_range(4));
      wide_vals = $urandom_range(1);
      for (int i = 0; i < nx; i++)
        for (int j = 0; j < ny; j++)
          feed_item(FN_WR_GRID, i, j,
                    wide_vals ? $urandom : $signed($urandom_range(1 << 21)) - (1 << 20),
                    $urandom, $urandom);
      for (int e = 0; e < 40; e++) begin
        if (p == 5 && e == 10) hold_req = 1;
        evaluate_at(pick_coord(1, nx), pick_coord(0, ny));
      end
      drain();
    end

    repeat (200) @(negedge clk);
    $display("Covered %0d evaluations (%0d saturated, %0d zero-width) over 13 table setups,",
             evals_seen, sat_seen, zero_seen);
    $display("point counts from clamped-low to clamped-high, with stalls on both sides.");
    if (errors == 0 && pending == 0) begin
      $display("bilinear_grid_interpolator_core verification clean");
    end else begin
      $display("bilinear_grid_interpolator_core verification failed");
    end
    $finish;
  end

endmodule

[files.f]
hdl/bgi_pkg.sv
hdl/bgi_ram.sv
hdl/bgi_search.sv
hdl/bgi_div.sv
hdl/bilinear_grid_interpolator_core.sv
tb/sv/bgi_result_checker.sv
tb/sv/bilinear_grid_interpolator_core_test.sv
